// File: hdl/adpcm4_pkg.sv
// shared types, codes and decode tables for the four-voice adpcm player
// depends on nothing; every other file imports it
package adpcm4_pkg;

  localparam int ROM_ADDR_BITS = 18;
  localparam int ROM_DEPTH     = 1 << ROM_ADDR_BITS;
  localparam int VOICE_COUNT   = 4;
  localparam int TBL_BYTES     = 6;
  localparam int STEP_MAX      = 48;

  // input kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // result kinds
  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_SAMPLE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [17:0] rom_address;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         status_byte;
    logic signed [15:0] mixed_sample;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       tbl_rd;
    logic       tbl_cap;
    logic       start;
    logic       v_rd;
    logic       v_dec;
    logic       v_mix;
    logic       emit;
    logic [2:0] idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phrase_pending;
    logic out_free;
  } stat_t;

  function automatic logic [10:0] step_size(input logic [5:0] k);
    logic [10:0] s;
    unique case (k)
      6'd0: s = 11'd16;    6'd1: s = 11'd17;    6'd2: s = 11'd19;    6'd3: s = 11'd21;
      6'd4: s = 11'd23;    6'd5: s = 11'd25;    6'd6: s = 11'd28;    6'd7: s = 11'd31;
      6'd8: s = 11'd34;    6'd9: s = 11'd37;    6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;   6'd15: s = 11'd66;
      6'd16: s = 11'd73;   6'd17: s = 11'd80;   6'd18: s = 11'd88;   6'd19: s = 11'd97;
      6'd20: s = 11'd107;  6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;  6'd27: s = 11'd209;
      6'd28: s = 11'd230;  6'd29: s = 11'd253;  6'd30: s = 11'd279;  6'd31: s = 11'd307;
      6'd32: s = 11'd337;  6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;  6'd39: s = 11'd658;
      6'd40: s = 11'd724;  6'd41: s = 11'd796;  6'd42: s = 11'd876;  6'd43: s = 11'd963;
      6'd44: s = 11'd1060; 6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      6'd48: s = 11'd1552;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_move(input logic [2:0] n);
    logic signed [4:0] m;
    unique case (n)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] gain_of_code(input logic [3:0] c);
    logic [5:0] g;
    unique case (c)
      4'd0:    g = 6'h20;
      4'd1:    g = 6'h16;
      4'd2:    g = 6'h10;
      4'd3:    g = 6'h0b;
      4'd4:    g = 6'h08;
      4'd5:    g = 6'h06;
      4'd6:    g = 6'h04;
      4'd7:    g = 6'h03;
      4'd8:    g = 6'h02;
      default: g = 6'h00;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/adpcm_four_voice_sample_player.sv
// top level of the four-voice adpcm sample player
// depends on adpcm4_pkg, adpcm4_ctrl, adpcm4_dp
//
//   channel | signals                     | carries
//   in      | in_valid, in_stall, in_item | bus events: command, status read, rom load, tick
//   out     | out_valid, out_stall, out_item | status answers and mixed samples
//
// rom loads and plain commands leave the sequencer idle; a status read waits for a free output register
// a tick reads, decodes and mixes each voice in turn through the single rom read port and decoder
// a phrase start reads and captures six table bytes, then makes one update
// rst is synchronous; the sample rom keeps its contents, all voices go idle
// a held result stalls only the final hand-off; the rom has no clearing pass
module adpcm_four_voice_sample_player import adpcm4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  assign in_stall = !idle;

  // sequencer
  adpcm4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_item.kind),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  // storage and arithmetic
  adpcm4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hdl/adpcm4_ctrl.sv
// sequencer for the adpcm player: walks table reads, voice decode and result hand-off
// depends on adpcm4_pkg
module adpcm4_ctrl import adpcm4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] in_kind,
  input  stat_t    stat,
  output logic     idle,
  output cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_TBL_RD  = 8'b0000_0010,
    S_TBL_CAP = 8'b0000_0100,
    S_START   = 8'b0000_1000,
    S_V_RD    = 8'b0001_0000,
    S_V_DEC   = 8'b0010_0000,
    S_V_MIX   = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] idx, idx_next;
  logic       accept;

  // no item is taken while reset is held
  assign idle   = (state == S_IDLE) && !rst;
  assign accept = idle && in_valid;

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = 3'd0;
        if (accept) begin
          priority if (in_kind == KIND_CMD && stat.phrase_pending) state_next = S_TBL_RD;
          else if (in_kind == KIND_STATUS) state_next = S_EMIT;
          else if (in_kind == KIND_TICK) state_next = S_V_RD;
          else state_next = S_IDLE;
        end
      end
      S_TBL_RD:  state_next = S_TBL_CAP;
      S_TBL_CAP: begin
        if (idx == 3'(TBL_BYTES - 1)) begin
          state_next = S_START;
        end else begin
          idx_next   = idx + 3'd1;
          state_next = S_TBL_RD;
        end
      end
      S_START:   state_next = S_IDLE;
      S_V_RD:    state_next = S_V_DEC;
      S_V_DEC:   state_next = S_V_MIX;
      S_V_MIX: begin
        if (idx == 3'(VOICE_COUNT - 1)) begin
          state_next = S_EMIT;
        end else begin
          idx_next   = idx + 3'd1;
          state_next = S_V_RD;
        end
      end
      S_EMIT:    if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // commands
  always_comb begin
    cmd.accept  = accept;
    cmd.tbl_rd  = (state == S_TBL_RD);
    cmd.tbl_cap = (state == S_TBL_CAP);
    cmd.start   = (state == S_START);
    cmd.v_rd    = (state == S_V_RD);
    cmd.v_dec   = (state == S_V_DEC);
    cmd.v_mix   = (state == S_V_MIX);
    cmd.emit    = (state == S_EMIT);
    cmd.idx     = idx;
  end

endmodule

// File: hdl/adpcm4_dp.sv
// datapath of the adpcm player: sample rom, voice state, decoder, mixer, output register
// depends on adpcm4_pkg
module adpcm4_dp import adpcm4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output stat_t     stat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  // sample memory
  logic [7:0]               rom [ROM_DEPTH];
  logic [7:0]               rd_data;
  logic [ROM_ADDR_BITS-1:0] rd_addr;
  logic                     rom_we;
  logic                     oob, oob_r;

  // command side state
  logic       phrase_pending;
  logic [6:0] pending_phrase;
  logic [7:0] value_byte;
  logic       item_kind_tick;
  logic [7:0] tbl [TBL_BYTES];

  // voices
  logic              playing   [VOICE_COUNT];
  logic [17:0]       base      [VOICE_COUNT];
  logic [19:0]       position  [VOICE_COUNT];
  logic [19:0]       length    [VOICE_COUNT];
  logic signed [11:0] signal   [VOICE_COUNT];
  logic [5:0]        step_idx  [VOICE_COUNT];
  logic [5:0]        gain      [VOICE_COUNT];

  // decode and mix
  logic signed [11:0] dec_sig;
  logic [4:0]         dec_gain;
  logic               dec_act;
  logic signed [18:0] sum;

  logic [1:0]  v;
  logic [19:0] vaddr;
  logic [17:0] start_a, stop_a;

  assign v = cmd.idx[1:0];

  // rom address and write
  always_comb begin
    vaddr = 20'(base[v]) + 20'(position[v][19:1]);
    oob   = 32'(vaddr) >= ROM_DEPTH;
    if (cmd.tbl_rd) rd_addr = ROM_ADDR_BITS'({pending_phrase, cmd.idx});
    else rd_addr = vaddr[ROM_ADDR_BITS-1:0];
    rom_we = cmd.accept && in_item.kind == KIND_LOAD && 32'(in_item.rom_address) < ROM_DEPTH;
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom[in_item.rom_address[ROM_ADDR_BITS-1:0]] <= in_item.data_byte;
    rd_data <= rom[rd_addr];
    oob_r   <= oob;
  end

  // phrase table bytes
  always_ff @(posedge clk) begin
    if (cmd.tbl_cap) tbl[cmd.idx] <= rd_data;
  end

  assign start_a = {tbl[0][1:0], tbl[1], tbl[2]};
  assign stop_a  = {tbl[3][1:0], tbl[4], tbl[5]};

  // nibble decode
  logic [7:0]         byte_v;
  logic [3:0]         nib;
  logic [14:0]        prod;
  logic [11:0]        mag;
  logic signed [13:0] sig_sum;
  logic signed [11:0] sig_new;
  logic signed [6:0]  k_sum;
  logic [5:0]         k_new;
  logic [19:0]        pos_next;

  always_comb begin
    byte_v   = oob_r ? 8'd0 : rd_data;
    nib      = position[v][0] ? byte_v[3:0] : byte_v[7:4];
    prod     = 15'(step_size(step_idx[v])) * 15'({nib[2:0], 1'b1});
    mag      = prod[14:3];
    sig_sum  = nib[3] ? 14'(signal[v]) - $signed({2'b00, mag})
                      : 14'(signal[v]) + $signed({2'b00, mag});
    if (sig_sum < -14'sd2048) sig_new = -12'sd2048;
    else if (sig_sum > 14'sd2047) sig_new = 12'sd2047;
    else sig_new = sig_sum[11:0];
    k_sum = $signed({1'b0, step_idx[v]}) + 7'(index_move(nib[2:0]));
    if (k_sum < 7'sd0) k_new = 6'd0;
    else if (k_sum > 7'(STEP_MAX)) k_new = 6'(STEP_MAX);
    else k_new = k_sum[5:0];
    pos_next = position[v] + 20'd1;
  end

  // command handling and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_pending <= 1'b0;
      pending_phrase <= 7'd0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        playing[i]  <= 1'b0;
        base[i]     <= 18'd0;
        position[i] <= 20'd0;
        length[i]   <= 20'd0;
        signal[i]   <= -12'sd2;
        step_idx[i] <= 6'd0;
        gain[i]     <= 6'd0;
      end
    end else begin
      if (cmd.accept && in_item.kind == KIND_CMD) begin
        priority if (phrase_pending) begin
          value_byte     <= in_item.data_byte;
          phrase_pending <= 1'b0;
        end else if (in_item.data_byte[7]) begin
          pending_phrase <= in_item.data_byte[6:0];
          phrase_pending <= 1'b1;
        end else begin
          for (int i = 0; i < VOICE_COUNT; i++)
            if (in_item.data_byte[3+i]) playing[i] <= 1'b0;
        end
      end
      // phrase start on each named idle voice, if the phrase is not empty
      if (cmd.start) begin
        for (int i = 0; i < VOICE_COUNT; i++) begin
          if (value_byte[4+i] && !playing[i] && start_a < stop_a) begin
            playing[i]  <= 1'b1;
            base[i]     <= start_a;
            position[i] <= 20'd0;
            length[i]   <= {19'(stop_a) - 19'(start_a) + 19'd1, 1'b0};
            signal[i]   <= -12'sd2;
            step_idx[i] <= 6'd0;
            gain[i]     <= gain_of_code(value_byte[3:0]);
          end
        end
      end
      if (cmd.v_dec && playing[v]) begin
        position[v] <= pos_next;
        if (pos_next >= length[v]) playing[v] <= 1'b0;
        signal[v]   <= sig_new;
        step_idx[v] <= k_new;
      end
    end
  end

  // decode result register, then scale and accumulate
  always_ff @(posedge clk) begin
    if (cmd.v_dec) begin
      dec_sig  <= sig_new;
      dec_gain <= gain[v][5:1];
      dec_act  <= playing[v];
    end
    if (cmd.accept) begin
      sum            <= 19'sd0;
      item_kind_tick <= in_item.kind == KIND_TICK;
    end else if (cmd.v_mix && dec_act) begin
      sum <= sum + 19'(dec_sig) * 19'($signed({1'b0, dec_gain}));
    end
  end

  // output register
  logic       out_free;
  logic [7:0] status_v;
  logic signed [15:0] sat_v;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status_v = 8'hf0;
    for (int i = 0; i < VOICE_COUNT; i++)
      if (playing[i]) status_v[i] = 1'b1;
    if (sum < -19'sd32767) sat_v = -16'sd32767;
    else if (sum > 19'sd32767) sat_v = 16'sd32767;
    else sat_v = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      if (item_kind_tick) begin
        out_item.result_kind  <= RES_SAMPLE;
        out_item.status_byte  <= 8'd0;
        out_item.mixed_sample <= sat_v;
      end else begin
        out_item.result_kind  <= RES_STATUS;
        out_item.status_byte  <= status_v;
        out_item.mixed_sample <= 16'sd0;
      end
    end
  end

  assign stat.phrase_pending = phrase_pending;
  assign stat.out_free       = out_free;

endmodule

// File: hdl/adpcm4_chk.sv
// port-level checks for the adpcm player, bound to the top level
// depends on adpcm4_pkg
module adpcm4_chk import adpcm4_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed");

  // loads and commands never produce a result
  a_no_res: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.kind == KIND_CMD || in_item.kind == KIND_LOAD)
      && !out_valid |=> !out_valid)
    else $error("result after a silent item");

  // status answer form
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind == RES_STATUS |->
      out_item.status_byte[7:4] == 4'hf && out_item.mixed_sample == 16'sd0)
    else $error("bad status answer");

  // sample answer form
  a_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind == RES_SAMPLE |->
      out_item.status_byte == 8'd0 && out_item.mixed_sample != -16'sd32768)
    else $error("bad sample answer");

  // a status read or tick blocks the input while it is worked
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.kind == KIND_STATUS || in_item.kind == KIND_TICK)
      |=> in_stall)
    else $error("input taken during a result item");

endmodule

bind adpcm_four_voice_sample_player adpcm4_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: bench/adpcm_four_voice_sample_player_tb.sv
// self-checking bench for the four-voice adpcm sample player
// depends on adpcm4_pkg and the adpcm_four_voice_sample_player rtl
// a behavioral voice model predicts each status answer and mixed sample
module adpcm_four_voice_sample_player_tb;
  import adpcm4_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1300;

  // sample regions that stay written for the whole run
  localparam int REGION_A = 18'h01000;
  localparam int REGION_B = 18'h3ffc0;
  localparam int RISE_BLOCK = 18'h02000;
  localparam int FALL_BLOCK = 18'h02020;
  localparam int PHRASE_SLOTS = 12;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  adpcm_four_voice_sample_player dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // decode tables
  int step_tbl [49] = '{
    16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
    73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
    337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963, 1060, 1166, 1282, 1411,
    1552};
  int move_tbl [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};
  int gain_tbl [16] = '{32, 22, 16, 11, 8, 6, 4, 3, 2, 0, 0, 0, 0, 0, 0, 0};

  // phrases whose table entries are loaded
  int phrase_ids [PHRASE_SLOTS] = '{0, 1, 2, 3, 4, 5, 6, 7, 42, 85, 100, 127};

  // model state of the player
  logic [7:0] rom_img [0:ROM_DEPTH-1];
  bit         arm_pending;
  bit [6:0]   armed_phrase;
  bit         v_playing [VOICE_COUNT];
  int         v_base [VOICE_COUNT];
  int         v_pos [VOICE_COUNT];
  int         v_len [VOICE_COUNT];
  int         v_signal [VOICE_COUNT];
  int         v_index [VOICE_COUNT];
  int         v_gain [VOICE_COUNT];

  out_item_t  answers_due [$];
  int         errors = 0;
  int         answers_seen = 0;
  int         items_sent = 0;
  int         clipped_samples = 0;
  int         cycles = 0;
  int         stall_left = 0;
  bit         calm_in = 1'b0;
  bit         calm_out = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int table_word(input int a);
    return {rom_img[a], rom_img[a+1], rom_img[a+2]} & 18'h3ffff;
  endfunction

  // one nibble of adpcm decode for voice v
  function automatic int decode_voice(input int v, input bit [3:0] nib);
    int s, m, sig, k;
    s = step_tbl[v_index[v]];
    m = s;
    if (nib[2]) m += 8 * s;
    if (nib[1]) m += 4 * s;
    if (nib[0]) m += 2 * s;
    m = m >>> 3;
    if (nib[3]) m = -m;
    sig = v_signal[v] + m;
    if (sig < -2048) sig = -2048;
    if (sig > 2047) sig = 2047;
    v_signal[v] = sig;
    k = v_index[v] + move_tbl[nib[2:0]];
    if (k < 0) k = 0;
    if (k > STEP_MAX) k = STEP_MAX;
    v_index[v] = k;
    return sig;
  endfunction

  // advance the model by one item; gives the answer it causes, if any
  function automatic bit predict_answer(input in_item_t it, output out_item_t ans);
    int start, stop, sum, sig;
    bit [7:0] b, st;
    ans = '0;
    case (it.kind)
      KIND_CMD: begin
        if (arm_pending) begin
          start = table_word(armed_phrase * 8);
          stop = table_word(armed_phrase * 8 + 3);
          for (int v = 0; v < VOICE_COUNT; v++) begin
            if (it.data_byte[4+v] && !v_playing[v] && start < stop) begin
              v_playing[v] = 1'b1;
              v_base[v] = start;
              v_pos[v] = 0;
              v_len[v] = 2 * (stop - start + 1);
              v_signal[v] = -2;
              v_index[v] = 0;
              v_gain[v] = gain_tbl[it.data_byte[3:0]];
            end
          end
          arm_pending = 1'b0;
        end else if (it.data_byte[7]) begin
          armed_phrase = it.data_byte[6:0];
          arm_pending = 1'b1;
        end else begin
          for (int v = 0; v < VOICE_COUNT; v++)
            if (it.data_byte[3+v]) v_playing[v] = 1'b0;
        end
        return 1'b0;
      end
      KIND_LOAD: begin
        rom_img[it.rom_address] = it.data_byte;
        return 1'b0;
      end
      KIND_STATUS: begin
        st = 8'hf0;
        for (int v = 0; v < VOICE_COUNT; v++) st[v] = v_playing[v];
        ans.result_kind = RES_STATUS;
        ans.status_byte = st;
        return 1'b1;
      end
      default: begin
        sum = 0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (v_playing[v]) begin
            b = rom_img[v_base[v] + (v_pos[v] >> 1)];
            v_pos[v] = (v_pos[v] + 1) & 20'hfffff;
            if (v_pos[v] >= v_len[v]) v_playing[v] = 1'b0;
            sig = decode_voice(v, v_pos[v][0] ? b[7:4] : b[3:0]);
            sum += sig * (v_gain[v] >> 1);
          end
        end
        if (sum < -32767 || sum > 32767) clipped_samples++;
        if (sum < -32767) sum = -32767;
        if (sum > 32767) sum = 32767;
        ans.result_kind = RES_SAMPLE;
        ans.mixed_sample = sum[15:0];
        return 1'b1;
      end
    endcase
  endfunction

  // drive one item and wait until it is taken
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [17:0] addr);
    in_item_t it;
    out_item_t ans;
    int gap;
    it.kind = kind;
    it.data_byte = data;
    it.rom_address = addr;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_answer(it, ans)) answers_due.push_back(ans);
    gap = calm_in ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item <= '0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_byte(input int addr, input int data);
    send_item(KIND_LOAD, data[7:0], addr[17:0]);
  endtask

  task automatic put_phrase(input int phrase, input int start, input int stop);
    put_byte(phrase * 8,     {$urandom_range(0, 63), start[17:16]});
    put_byte(phrase * 8 + 1, start[15:8]);
    put_byte(phrase * 8 + 2, start[7:0]);
    put_byte(phrase * 8 + 3, {$urandom_range(0, 63), stop[17:16]});
    put_byte(phrase * 8 + 4, stop[15:8]);
    put_byte(phrase * 8 + 5, stop[7:0]);
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(KIND_TICK, $urandom, $urandom);
  endtask

  task automatic command(input int b);
    send_item(KIND_CMD, b[7:0], $urandom);
  endtask

  // rom image: sample regions, steady blocks and the phrase table
  task automatic test_rom_load();
    int s;
    calm_in = 1'b1;
    for (int i = 0; i < 64; i++) put_byte(REGION_A + i, $urandom);
    for (int i = 0; i < 64; i++) put_byte(REGION_B + i, $urandom);
    for (int i = 0; i < 32; i++) put_byte(RISE_BLOCK + i, 8'h77);
    for (int i = 0; i < 32; i++) put_byte(FALL_BLOCK + i, 8'hff);
    // start equal to stop and start above stop are both empty
    put_phrase(0, REGION_A + 5, REGION_A + 5);
    put_phrase(127, REGION_B + 40, REGION_B + 2);
    put_phrase(1, RISE_BLOCK, RISE_BLOCK + 31);
    put_phrase(2, FALL_BLOCK, FALL_BLOCK + 31);
    for (int p = 3; p < PHRASE_SLOTS - 1; p++) begin
      s = $urandom_range(0, 47);
      put_phrase(phrase_ids[p], (p < 7 ? REGION_A : REGION_B) + s,
                 (p < 7 ? REGION_A : REGION_B) + s + $urandom_range(1, 16));
    end
    calm_in = 1'b0;
  endtask

  // idle answers: status with no voice, tick with no voice
  task automatic test_idle_answers();
    send_item(KIND_STATUS, 8'hff, 18'h3ffff);
    tick(2);
  endtask

  // full-scale mixes, busy voices, stop commands, silent volume, empty phrases
  task automatic test_directed_play();
    command(8'h81); command(8'hf0);   // all voices rising, loudest volume
    tick(6);
    command(8'h82); command(8'h18);   // voice 0 busy, left alone
    send_item(KIND_STATUS, 8'h00, 18'h0);
    command(8'h78);                   // stop all
    command(8'h82); command(8'hf0);   // all voices falling
    tick(6);
    command(8'h08); command(8'h30);   // stop voices 0, then 1 and 2
    command(8'h85); command(8'h8f);   // voice byte with bit 7 set, silent volume
    tick(2);
    command(8'h80); command(8'hf3);   // empty phrase, start equals stop
    command(8'hff); command(8'hf7);   // empty phrase, start above stop
    send_item(KIND_STATUS, 8'h00, 18'h0);
  endtask

  // random mix dominated by ticks, with well-formed phrase starts
  task automatic test_random_mix();
    int r, b;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // finish an armed phrase first so the next byte arms a loaded one
        if (arm_pending) command($urandom);
        command(8'h80 | phrase_ids[$urandom_range(0, PHRASE_SLOTS - 1)]);
        command($urandom);
      end else if (r < 16) begin
        b = $urandom_range(0, 255);
        if (!arm_pending && b[7]) b = 8'h80 | phrase_ids[$urandom_range(0, PHRASE_SLOTS - 1)];
        command(b);
      end else if (r < 26) begin
        send_item(KIND_STATUS, $urandom, $urandom);
      end else if (r < 32) begin
        // keep the phrase table intact
        b = $urandom_range(0, ROM_DEPTH - 1);
        if (b < 1024) b += 1024;
        put_byte(b, $urandom);
      end else if (r < 35) begin
        put_byte((r & 1) ? REGION_A + $urandom_range(0, 63) : REGION_B + $urandom_range(0, 63),
                 $urandom);
      end else begin
        tick(1);
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm_out && $urandom_range(0, 2) == 0) stall_left <= gap_len();
    end
  end

  // compare each answer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer %h", $time, out_item);
      end else begin
        want = answers_due.pop_front();
        if (out_item.result_kind !== want.result_kind) begin
          errors++;
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   want.result_kind, out_item.result_kind);
        end
        if (out_item.status_byte !== want.status_byte) begin
          errors++;
          $display("%0t: status_byte expected %h actual %h", $time,
                   want.status_byte, out_item.status_byte);
        end
        if (out_item.mixed_sample !== want.mixed_sample) begin
          errors++;
          $display("%0t: mixed_sample expected %0d actual %0d", $time,
                   want.mixed_sample, out_item.mixed_sample);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("adpcm_four_voice_sample_player verification failed");
      $finish;
    end
  end

  initial begin
    arm_pending = 1'b0;
    armed_phrase = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      v_playing[v] = 1'b0;
      v_base[v] = 0;
      v_pos[v] = 0;
      v_len[v] = 0;
      v_signal[v] = -2;
      v_index[v] = 0;
      v_gain[v] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rom_load();
    test_idle_answers();
    test_directed_play();
    test_random_mix();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items, %0d answers, %0d clipped mixes", items_sent,
             answers_seen, clipped_samples);
    if (errors == 0) begin
      $display("adpcm_four_voice_sample_player verification clean");
    end else begin
      $display("adpcm_four_voice_sample_player verification failed");
    end
    $finish;
  end

endmodule
